@@ sv/cbk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the cubic B-spline kernel.
// No dependencies; imported by every module of the block.
package cbk_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 18;
    localparam int FAC_W       = 18;
    localparam int CHAIN_W     = 19;
    localparam int VALUE_W     = 18;
    localparam int GRAD_W      = 19;
    localparam int NUM_LANES   = 3;
    localparam int NDIM_W      = 2;

    localparam int LANE_STAGES = 5;
    localparam int PROD_STAGES = 3;
    localparam int PIPE_STAGES = LANE_STAGES + PROD_STAGES;

    localparam int S_TDATA_W   = ((NUM_LANES * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VALUE_W + NUM_LANES * GRAD_W + 7) / 8) * 8;

    localparam logic [NDIM_W-1:0]  NUM_DIMS_RST = 2'd3;
    localparam logic [COORD_W-1:0] ONE          = COORD_W'(1 << FRAC_BITS);
    localparam logic [COORD_W-1:0] HALF         = COORD_W'(1 << (FRAC_BITS - 1));
    localparam logic [20:0]        RECIP3       = 21'd1398102;
    localparam logic [VALUE_W-1:0] VALUE_MAX    = '1;
    localparam logic [GRAD_W-1:0]  GRAD_POS_MAX = GRAD_W'((1 << (GRAD_W - 1)) - 1);
    localparam logic [GRAD_W-1:0]  GRAD_NEG_MAX = GRAD_W'(1 << (GRAD_W - 1));

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [FAC_W-1:0]          t_fac;
    typedef logic [CHAIN_W-1:0]        t_chain;

    typedef struct packed {
        t_fac v;
        t_fac g;
        logic neg;
        logic oob;
    } t_lane;

    // floor(x / 3) for x below 2^20
    function automatic t_fac div3(input logic [19:0] x);
        logic [40:0] pr;
        pr = 41'(x) * 41'(RECIP3);
        return pr[39:22];
    endfunction

    function automatic t_chain fx_mul(input t_chain a, input t_fac b);
        logic [36:0] pr;
        pr = 37'(a) * 37'(b);
        return pr[FRAC_BITS+CHAIN_W-1:FRAC_BITS];
    endfunction

    function automatic logic [GRAD_W-1:0] sat_grad(input t_chain mag, input logic negative);
        logic [GRAD_W-1:0] m;
        if (negative) begin
            m = (GRAD_W'(mag) > GRAD_NEG_MAX) ? GRAD_NEG_MAX : GRAD_W'(mag);
            return GRAD_W'(~m + 1'b1);
        end
        return (GRAD_W'(mag) > GRAD_POS_MAX) ? GRAD_POS_MAX : GRAD_W'(mag);
    endfunction

    function automatic logic [VALUE_W-1:0] sat_value(input t_chain mag);
        return (mag > CHAIN_W'(VALUE_MAX)) ? VALUE_MAX : mag[VALUE_W-1:0];
    endfunction

endpackage

@@ sv/cbk_factor.sv @@
`timescale 1ns / 1ps
// One dimension's B-spline value and derivative factors, five register stages.
// Depends on cbk_pkg.
module cbk_factor
    import cbk_pkg::*;
(
    input  logic                   i_clk,
    input  logic [LANE_STAGES-1:0] i_en,
    input  t_coord                 i_coord,
    output t_lane                  o_lane
);

    logic [COORD_W-1:0] n_a;
    logic [COORD_W-1:0] n_tw;
    logic               n_neg;

    logic [15:0] r_s0_a, r_s0_x;
    logic [16:0] r_s0_t;
    logic        r_s0_inner, r_s0_neg, r_s0_oob;

    logic [31:0] n_s1_pp;
    logic [14:0] r_s1_p;
    logic [15:0] r_s1_a;
    logic [16:0] r_s1_t;
    logic        r_s1_inner, r_s1_neg, r_s1_oob;

    logic [31:0] n_s2_pq;
    logic [14:0] r_s2_q, r_s2_p;
    logic [15:0] r_s2_a;
    logic        r_s2_inner, r_s2_neg, r_s2_oob;

    logic [19:0] n_s3_b, n_s3_m, w_q20, w_p20, w_a20;
    logic [16:0] r_s3_b;
    logic [17:0] r_s3_m;
    logic        r_s3_neg, r_s3_oob;

    t_fac r_s4_v, r_s4_g;
    logic r_s4_neg, r_s4_oob;

    always_comb begin
        n_neg = i_coord[COORD_W-1];
        n_a   = n_neg ? COORD_W'(-i_coord) : COORD_W'(i_coord);
        n_tw  = ONE - n_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_a     <= n_a[15:0];
            r_s0_t     <= n_tw[16:0];
            r_s0_x     <= (n_a <= HALF) ? n_a[15:0] : n_tw[15:0];
            r_s0_inner <= (n_a <= HALF);
            r_s0_neg   <= n_neg;
            r_s0_oob   <= (n_a > ONE);
        end
    end

    assign n_s1_pp = 32'(r_s0_x) * 32'(r_s0_x);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_p     <= n_s1_pp[FRAC_BITS+14:FRAC_BITS];
            r_s1_a     <= r_s0_a;
            r_s1_t     <= r_s0_t;
            r_s1_inner <= r_s0_inner;
            r_s1_neg   <= r_s0_neg;
            r_s1_oob   <= r_s0_oob;
        end
    end

    assign n_s2_pq = 32'(r_s1_p) * 32'(r_s1_t);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_q     <= n_s2_pq[FRAC_BITS+14:FRAC_BITS];
            r_s2_p     <= r_s1_p;
            r_s2_a     <= r_s1_a;
            r_s2_inner <= r_s1_inner;
            r_s2_neg   <= r_s1_neg;
            r_s2_oob   <= r_s1_oob;
        end
    end

    always_comb begin
        w_q20 = 20'(r_s2_q);
        w_p20 = 20'(r_s2_p);
        w_a20 = 20'(r_s2_a);
        if (r_s2_inner) begin
            n_s3_b = 20'(ONE) - ((w_q20 << 2) + (w_q20 << 1));
            n_s3_m = ((w_a20 << 3) + (w_a20 << 2)) - ((w_p20 << 4) + (w_p20 << 1));
        end else begin
            n_s3_b = w_q20 << 1;
            n_s3_m = (w_p20 << 2) + (w_p20 << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_b   <= n_s3_b[16:0];
            r_s3_m   <= n_s3_m[17:0];
            r_s3_neg <= r_s2_neg;
            r_s3_oob <= r_s2_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_v   <= div3(20'({r_s3_b, 2'b00}));
            r_s4_g   <= div3({r_s3_m, 2'b00});
            r_s4_neg <= r_s3_neg;
            r_s4_oob <= r_s3_oob;
        end
    end

    assign o_lane = '{v: r_s4_v, g: r_s4_g, neg: r_s4_neg, oob: r_s4_oob};

endmodule

@@ sv/cbk_product.sv @@
`timescale 1ns / 1ps
// Tensor products of the lane factors, saturation and sign, three register stages.
// Depends on cbk_pkg.
module cbk_product
    import cbk_pkg::*;
(
    input  logic                               i_clk,
    input  logic [PROD_STAGES-1:0]             i_en,
    input  t_lane [NUM_LANES-1:0]              i_lane,
    input  logic [NUM_LANES-1:0]               i_used,
    output logic [VALUE_W-1:0]                 o_kernel_value,
    output logic [NUM_LANES-1:0][GRAD_W-1:0]   o_grad
);

    t_fac   n_fv0, n_fv1, n_fv2;
    t_chain r_c0, r_c1, r_c2;
    t_fac   r_v2, r_g2;
    logic   r_s0_zero;
    logic [NUM_LANES-1:0] r_s0_neg;

    t_chain r_k, r_d0, r_d1, r_d2;
    logic   r_s1_zero;
    logic [NUM_LANES-1:0] r_s1_neg;

    logic [VALUE_W-1:0]               r_kernel;
    logic [NUM_LANES-1:0][GRAD_W-1:0] r_grad;
    t_chain                           n_d [NUM_LANES];

    always_comb begin
        n_fv0 = i_used[0] ? i_lane[0].v : FAC_W'(ONE);
        n_fv1 = i_used[1] ? i_lane[1].v : FAC_W'(ONE);
        n_fv2 = i_used[2] ? i_lane[2].v : FAC_W'(ONE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_c0      <= fx_mul(CHAIN_W'(n_fv0), n_fv1);
            r_c1      <= fx_mul(CHAIN_W'(i_lane[0].g), n_fv1);
            r_c2      <= fx_mul(CHAIN_W'(n_fv0), i_lane[1].g);
            r_v2      <= n_fv2;
            r_g2      <= i_lane[2].g;
            r_s0_zero <= (i_used[0] & i_lane[0].oob) | (i_used[1] & i_lane[1].oob)
                       | (i_used[2] & i_lane[2].oob);
            r_s0_neg  <= {i_lane[2].neg, i_lane[1].neg, i_lane[0].neg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_k       <= fx_mul(r_c0, r_v2);
            r_d0      <= fx_mul(r_c1, r_v2);
            r_d1      <= fx_mul(r_c2, r_v2);
            r_d2      <= fx_mul(r_c0, r_g2);
            r_s1_zero <= r_s0_zero;
            r_s1_neg  <= r_s0_neg;
        end
    end

    always_comb begin
        n_d[0] = r_d0;
        n_d[1] = r_d1;
        n_d[2] = r_d2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_kernel <= r_s1_zero ? '0 : sat_value(r_k);
            for (int k = 0; k < NUM_LANES; k++) begin
                r_grad[k] <= (r_s1_zero || !i_used[k]) ? '0
                           : sat_grad(n_d[k], !r_s1_neg[k] && (n_d[k] != '0));
            end
        end
    end

    assign o_kernel_value = r_kernel;
    assign o_grad         = r_grad;

endmodule

@@ sv/cubic_bspline_kernel_gradient.sv @@
`timescale 1ns / 1ps
// Tensor-product cubic B-spline kernel value and gradient, top level.
// Depends on cbk_pkg, cbk_factor and cbk_product.
//
// Usage: one beat on the slave stream carries three Q1.16 coordinates; one
// beat on the master stream returns the Q2.16 kernel value and three Q2.16
// gradient components. num_dims (written through i_cfg_wen/i_cfg_wdata while
// no beat is in flight) selects how many coordinates enter the product; a
// value of zero acts as one, and values above MAX_DIMS act as MAX_DIMS.
// Any used coordinate outside [-1, 1] returns all-zero fields.
// Pipeline: eight register stages (five per dimension lane, three for the
// products and saturation). Throughput: one beat per cycle while the receiver
// keeps taking results.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or advancing, so while the receiver stalls the input keeps taking
// beats until every stage is full; nothing is dropped or duplicated.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets num_dims to 3.
module cubic_bspline_kernel_gradient
    import cbk_pkg::*;
#(
    parameter int MAX_DIMS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [NDIM_W-1:0]     i_cfg_wdata,     // num_dims
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,  // coord_0, coord_1, coord_2
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata   // kernel_value, grad_0, grad_1, grad_2
);

    localparam logic [NDIM_W-1:0] MAX_D = NDIM_W'(MAX_DIMS);

    logic [NDIM_W-1:0]                r_num_dims;
    logic [NDIM_W-1:0]                w_ndim;
    logic [NUM_LANES-1:0]             w_used;
    logic [PIPE_STAGES-1:0]           r_vld, n_vld, w_en;
    t_lane [NUM_LANES-1:0]            w_lane;
    logic [VALUE_W-1:0]               w_kernel;
    logic [NUM_LANES-1:0][GRAD_W-1:0] w_grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_RST;
        end else if (i_cfg_wen) begin
            r_num_dims <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_ndim = r_num_dims;
        if (w_ndim == '0) begin
            w_ndim = NDIM_W'(1);
        end
        if (w_ndim > MAX_D) begin
            w_ndim = MAX_D;
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            w_used[i] = (NDIM_W'(i) < w_ndim) && (i < MAX_DIMS);
        end
    end

    always_comb begin
        w_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_m_axis_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
        n_vld[0] = w_en[0] ? i_s_axis_tvalid : r_vld[0];
        for (int i = 1; i < PIPE_STAGES; i++) begin
            n_vld[i] = w_en[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    for (genvar gi = 0; gi < NUM_LANES; gi++) begin : g_lane
        if (gi < MAX_DIMS) begin : g_on
            cbk_factor u_factor (
                .i_clk   (i_clk),
                .i_en    (w_en[LANE_STAGES-1:0]),
                .i_coord (t_coord'(i_s_axis_tdata[gi*COORD_W +: COORD_W])),
                .o_lane  (w_lane[gi])
            );
        end else begin : g_off
            assign w_lane[gi] = '0;
        end
    end

    cbk_product u_product (
        .i_clk          (i_clk),
        .i_en           (w_en[PIPE_STAGES-1:LANE_STAGES]),
        .i_lane         (w_lane),
        .i_used         (w_used),
        .o_kernel_value (w_kernel),
        .o_grad         (w_grad)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[PIPE_STAGES-1];
    assign o_m_axis_tdata  = M_TDATA_W'({w_grad[2], w_grad[1], w_grad[0], w_kernel});

    a_unused_grad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !w_used[1]) |-> (w_grad[1] == '0 && w_grad[2] == '0))
        else $error("gradient of an unused dimension is not zero");

    a_empty_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while the output stage is empty");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted beat did not enter the first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

@@ tb/cbk_kernel_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for cubic_bspline_kernel_gradient: watches both streams and the config port,
// predicts each result beat from the accepted coordinates and compares field by field.
// Depends on cbk_pkg for widths and the reset value of num_dims.
module cbk_kernel_checker
    import cbk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [NDIM_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,    // coord_0, coord_1, coord_2
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,    // kernel_value, grad_0, grad_1, grad_2
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [VALUE_W-1:0]                value;
        logic [NUM_LANES-1:0][GRAD_W-1:0] grad;
    } t_kernel_beat;

    localparam logic [63:0] UNIT      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] GRAD_TOP  = 64'd1 << (GRAD_W - 1);
    localparam logic [63:0] VALUE_TOP = (64'd1 << VALUE_W) - 1;

    t_kernel_beat      kernel_q[$];
    logic [NDIM_W-1:0] num_dims_q;
    int                n_reported = 0;

    function automatic logic [GRAD_W-1:0] clamp_grad(input logic [63:0] mag,
                                                     input logic negative);
        logic [63:0] lim;
        if (negative) begin
            lim = (mag > GRAD_TOP) ? GRAD_TOP : mag;
            return GRAD_W'(64'd0 - lim);
        end
        return (mag > GRAD_TOP - 1) ? GRAD_W'(GRAD_TOP - 1) : GRAD_W'(mag);
    endfunction

    function automatic t_kernel_beat kernel_of(input logic [S_TDATA_W-1:0] coords,
                                               input logic [NDIM_W-1:0] dims);
        logic [63:0]        vfac [NUM_LANES];
        logic [63:0]        gfac [NUM_LANES];
        logic               gneg [NUM_LANES];
        logic [COORD_W-1:0] raw;
        logic [63:0]        mag, sq, cu, t, tt, b, m, acc;
        int                 n;
        t_kernel_beat       r;
        r = '0;
        n = (dims == 0) ? 1 : int'(dims);
        if (n > NUM_LANES)
            n = NUM_LANES;
        for (int i = 0; i < n; i++) begin
            raw = coords[i*COORD_W +: COORD_W];
            mag = raw[COORD_W-1] ? ((64'd1 << COORD_W) - 64'(raw)) : 64'(raw);
            if (mag > UNIT)
                return '0;
            if (mag <= (UNIT >> 1)) begin
                sq = (mag * mag) >> FRAC_BITS;
                cu = (sq * (UNIT - mag)) >> FRAC_BITS;
                b  = UNIT - 64'd6 * cu;
                m  = 64'd12 * mag - 64'd18 * sq;
            end else begin
                t  = UNIT - mag;
                tt = (t * t) >> FRAC_BITS;
                b  = 64'd2 * ((tt * t) >> FRAC_BITS);
                m  = 64'd6 * tt;
            end
            vfac[i] = (64'd4 * b) / 64'd3;
            gfac[i] = (64'd4 * m) / 64'd3;
            gneg[i] = !raw[COORD_W-1] && (gfac[i] != 0);
        end
        acc = UNIT;
        for (int i = 0; i < n; i++)
            acc = (acc * vfac[i]) >> FRAC_BITS;
        r.value = (acc > VALUE_TOP) ? VALUE_W'(VALUE_TOP) : VALUE_W'(acc);
        for (int k = 0; k < n; k++) begin
            acc = UNIT;
            for (int i = 0; i < n; i++)
                acc = (acc * ((i == k) ? gfac[i] : vfac[i])) >> FRAC_BITS;
            r.grad[k] = clamp_grad(acc, gneg[k] && (acc != 0));
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        o_fail_count++;
        if (n_reported < 10) begin
            n_reported++;
            $display("%0t kernel mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_kernel_beat got;
        t_kernel_beat want;
        if (!i_rst_n) begin
            num_dims_q   = NUM_DIMS_RST;
            o_fail_count = 0;
            kernel_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                kernel_q.push_back(kernel_of(i_s_tdata, num_dims_q));
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata[VALUE_W-1:0];
                for (int k = 0; k < NUM_LANES; k++)
                    got.grad[k] = i_m_tdata[VALUE_W + k*GRAD_W +: GRAD_W];
                if (kernel_q.size() == 0) begin
                    note_mismatch("unexpected beat, kernel_value", -1, got.value);
                end else begin
                    want = kernel_q.pop_front();
                    if (got.value !== want.value)
                        note_mismatch("kernel_value", want.value, got.value);
                    for (int k = 0; k < NUM_LANES; k++)
                        if (got.grad[k] !== want.grad[k])
                            note_mismatch($sformatf("grad_%0d", k), $signed(want.grad[k]),
                                          $signed(got.grad[k]));
                end
            end
            if (i_cfg_wen)
                num_dims_q = i_cfg_wdata;
        end
        o_pending = kernel_q.size();
    end

endmodule

@@ tb/tb_cubic_bspline_kernel_gradient.sv @@
`timescale 1ns / 1ps
// Top of the cubic_bspline_kernel_gradient testbench: clock, reset, config writes and stimulus.
// Depends on cbk_pkg, the block itself and cbk_kernel_checker, which does all the checking.
module tb_cubic_bspline_kernel_gradient;
    import cbk_pkg::*;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wen       = 1'b0;
    logic [NDIM_W-1:0]    i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int rx_hold       = 0;

    cubic_bspline_kernel_gradient DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    cbk_kernel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #2_000_000;
        $display("tb_cubic_bspline_kernel_gradient NOT OK");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when rx_hold is set
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return COORD_W'($urandom_range(2 * 65536) - 65536);
        if (r < 87) begin
            case ($urandom_range(9))
                0: return COORD_W'(65536);
                1: return COORD_W'(-65536);
                2: return COORD_W'(32768);
                3: return COORD_W'(-32768);
                4: return COORD_W'(32769);
                5: return COORD_W'(-32769);
                6: return COORD_W'(65535);
                7: return COORD_W'(-65535);
                8: return COORD_W'(65537);
                default: return '0;
            endcase
        end
        return COORD_W'($urandom());
    endfunction

    task automatic send_beat(input logic [COORD_W-1:0] c0, input logic [COORD_W-1:0] c1,
                             input logic [COORD_W-1:0] c2);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_TDATA_W'({c2, c1, c0});
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_beat(pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (2 * PIPE_STAGES) @(negedge i_clk);
    endtask

    task automatic write_num_dims(input logic [NDIM_W-1:0] dims);
        drain_results();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= dims;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 32;
        sink_idle_pct = 61;
        send_beat(18'd0, 18'd0, 18'd0);
        send_beat(18'd65536, 18'd0, 18'd0);
        send_beat(-18'sd65536, 18'd0, 18'd0);
        send_beat(18'd65537, 18'd0, 18'd0);
        send_beat(-18'sd65537, 18'd0, 18'd0);
        send_beat(18'h20000, 18'd0, 18'd0);
        send_beat(18'h1FFFF, 18'd0, 18'd0);
        send_beat(18'd32768, 18'd32768, 18'd32768);
        send_beat(-18'sd32768, -18'sd32768, -18'sd32768);
        send_beat(18'd32769, -18'sd32769, 18'd0);
        send_beat(-18'sd21845, 18'd0, 18'd0);
        send_beat(18'd21845, 18'd0, 18'd0);
        send_beat(-18'sd21845, -18'sd1, 18'd1);
        send_beat(18'd0, 18'd0, 18'd65537);
        send_beat(18'd0, 18'h20000, 18'd0);
        send_beat(18'd1, -18'sd1, 18'd65535);
        send_beat(-18'sd65535, 18'd65535, 18'd0);
        send_beat(18'h2AAAA, 18'h15555, 18'h3FFFF);

        write_num_dims(2'd1);
        send_beat(18'd21845, 18'h20000, 18'h1FFFF);
        send_random(90);
        write_num_dims(2'd0);
        send_random(40);

        src_idle_pct  = 61;
        sink_idle_pct = 32;
        write_num_dims(2'd2);
        send_random(110);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_num_dims(2'd3);
        send_random(80);
        rx_hold = 48;
        send_random(40);
        send_random(30);

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("tb_cubic_bspline_kernel_gradient OK");
        else
            $display("tb_cubic_bspline_kernel_gradient NOT OK");
        $finish;
    end

endmodule

@@ cubic_bspline_kernel_gradient.f @@
sv/cbk_pkg.sv
sv/cbk_factor.sv
sv/cbk_product.sv
sv/cubic_bspline_kernel_gradient.sv
tb/cbk_kernel_checker.sv
tb/tb_cubic_bspline_kernel_gradient.sv
